>>> rtl/look_at_view_matrix_macros.svh
// ----------------------------------------------------------------------------
// Look-at view matrix: assertion macros
// Concurrent check wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define LAV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define LAV_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LAV_ASSERT(lbl, clk, rst_n, prop, msg)
`define LAV_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: shared package
// Widths, word types and small arithmetic helpers used across the block.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int IN_W    = 32;             // Q16.16 input / output element
    localparam int D_W     = IN_W + 1;       // exact target - eye
    localparam int NV_W    = 50;             // widest vector fed to normalize
    localparam int MAG_W   = NV_W - 1;       // its magnitude
    localparam int AX_W    = 20;             // unit axis element, Q4.16
    localparam int MUL_W   = 33;             // shared multiplier operand
    localparam int ACC_W   = 56;             // product / sum accumulator
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int ROW_W   = 2;

    localparam logic [ROW_W-1:0]       LAST_ROW = 2'd3;
    localparam logic signed [IN_W-1:0] FIX_ONE  = 32'sh0001_0000;

    typedef logic signed [NV_W-1:0] t_nvec;
    typedef logic signed [AX_W-1:0] t_axis;

    // one accepted word, front to back
    typedef struct packed {
        logic signed [D_W-1:0]  d_x;
        logic signed [D_W-1:0]  d_y;
        logic signed [D_W-1:0]  d_z;
        logic signed [IN_W-1:0] eye_x;
        logic signed [IN_W-1:0] eye_y;
        logic signed [IN_W-1:0] eye_z;
        logic signed [IN_W-1:0] up_x;
        logic signed [IN_W-1:0] up_y;
        logic signed [IN_W-1:0] up_z;
    } t_item;

    // normalize unit status
    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_rsp;

    // finished matrix handed to the row emitter
    typedef struct packed {
        logic signed [AX_W-1:0] x0;
        logic signed [AX_W-1:0] x1;
        logic signed [AX_W-1:0] x2;
        logic signed [AX_W-1:0] y0;
        logic signed [AX_W-1:0] y1;
        logic signed [AX_W-1:0] y2;
        logic signed [AX_W-1:0] z0;
        logic signed [AX_W-1:0] z1;
        logic signed [AX_W-1:0] z2;
        logic signed [IN_W-1:0] w0;
        logic signed [IN_W-1:0] w1;
        logic signed [IN_W-1:0] w2;
        logic                   degen;
    } t_matrix;

    // cross product operand order: a1b2 a2b1 a2b0 a0b2 a0b1 a1b0
    function automatic logic [1:0] xp_ia(input logic [2:0] s);
        logic [1:0] r;
        unique case (s)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] xp_ib(input logic [2:0] s);
        logic [1:0] r;
        unique case (s)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // pick one of three operands, zero for an unused index
    function automatic logic signed [MUL_W-1:0] pick3(
        input logic [1:0] i,
        input logic signed [MUL_W-1:0] a0,
        input logic signed [MUL_W-1:0] a1,
        input logic signed [MUL_W-1:0] a2
    );
        logic signed [MUL_W-1:0] r;
        case (i)
            2'd0:    r = a0;
            2'd1:    r = a1;
            2'd2:    r = a2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q32.32 to Q16.16, halves away from zero
    function automatic logic signed [ACC_W-1:0] rnd_q16(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r   = (mag + ACC_W'(32768)) >> 16;
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [IN_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [IN_W-1:0]  r;
        hi = {{(ACC_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}};
        lo = {{(ACC_W-IN_W+1){1'b1}}, {(IN_W-1){1'b0}}};
        if (v > hi) begin
            r = hi[IN_W-1:0];
        end else if (v < lo) begin
            r = lo[IN_W-1:0];
        end else begin
            r = v[IN_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/lav_queue.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: command queue
// Short FIFO between the accepting front and the compute back end.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module lav_queue import lav_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty,
    output logic  o_full
);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));

    `LAV_NEVER(a_q_overflow, i_clk, i_rst_n, i_push && o_full, "queue push while full")
    `LAV_NEVER(a_q_underflow, i_clk, i_rst_n, i_pop && o_empty, "queue pop while empty")

endmodule

>>> rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: vector normalize unit
// Scales a 3-vector to unit length in Q4.16: range shift, sum of squares,
// bit-serial square root, bit-serial divide per component.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_nvec     i_vec [3],
    output t_norm_rsp o_rsp,
    output t_axis     o_vec [3]
);

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SHR  = 3'd1;
    localparam logic [2:0] N_SHL  = 3'd2;
    localparam logic [2:0] N_SQ   = 3'd3;
    localparam logic [2:0] N_SQRT = 3'd4;
    localparam logic [2:0] N_DVL  = 3'd5;
    localparam logic [2:0] N_DVS  = 3'd6;
    localparam logic [2:0] N_DONE = 3'd7;

    logic [2:0]       r_state;
    logic [MAG_W-1:0] r_mag [3];
    logic             r_neg [3];
    logic [MAG_W-1:0] r_mx;
    logic [4:0]       r_cnt;
    logic [1:0]       r_idx;
    logic [61:0]      r_prod;
    logic [63:0]      r_sum;
    logic [63:0]      r_num;
    logic [63:0]      r_res;
    logic [63:0]      r_bit;
    logic [47:0]      r_dvd;
    logic [31:0]      r_rem;
    logic [16:0]      r_q;
    t_axis            r_out [3];
    logic             r_zero;

    logic [MAG_W-1:0] in_mag [3];
    logic [MAG_W-1:0] in_mx;
    logic [NV_W-1:0]  abs_v [3];
    logic [30:0]      sel_m;
    logic [63:0]      trial;
    logic [31:0]      len;
    logic [47:0]      dvd;
    logic [32:0]      rem2;
    logic             ge;
    logic [16:0]      qn;
    logic [16:0]      dvd_lo;

    // magnitudes and largest one of the incoming vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_v[i]  = i_vec[i][NV_W-1] ? NV_W'(-i_vec[i]) : NV_W'(i_vec[i]);
            in_mag[i] = abs_v[i][MAG_W-1:0];
        end
        in_mx = in_mag[0];
        if (in_mag[1] > in_mx) begin
            in_mx = in_mag[1];
        end
        if (in_mag[2] > in_mx) begin
            in_mx = in_mag[2];
        end
    end

    // component chosen for squaring or dividing
    always_comb begin
        case ((r_state == N_SQ) ? r_cnt[1:0] : r_idx)
            2'd0:    sel_m = r_mag[0][30:0];
            2'd1:    sel_m = r_mag[1][30:0];
            2'd2:    sel_m = r_mag[2][30:0];
            default: sel_m = '0;
        endcase
    end

    // root step, divider step
    always_comb begin
        trial  = r_res + r_bit;
        len    = r_res[31:0];
        dvd    = {1'b0, sel_m, 16'b0} + 48'(len[31:1]);
        dvd_lo = r_dvd[16:0];
        rem2   = {r_rem, dvd_lo[r_cnt]};
        ge     = (rem2 >= {1'b0, len});
        qn     = {r_q[15:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= in_mag[i];
                            r_neg[i] <= i_vec[i][NV_W-1];
                        end
                        r_mx <= in_mx;
                        if (in_mx == '0) begin
                            for (int i = 0; i < 3; i++) begin
                                r_out[i] <= '0;
                            end
                            r_zero  <= 1'b1;
                            r_state <= N_DONE;
                        end else begin
                            r_zero  <= 1'b0;
                            r_state <= N_SHR;
                        end
                    end
                end
                // bring largest magnitude below 2^31
                N_SHR: begin
                    if (r_mx[MAG_W-1:31] != '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                        r_mx <= r_mx >> 1;
                    end else begin
                        r_state <= N_SHL;
                    end
                end
                // then up to at least 2^30
                N_SHL: begin
                    if (!r_mx[30]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                        r_mx <= r_mx << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= N_SQ;
                    end
                end
                // sum of squares, one product per cycle
                N_SQ: begin
                    if (r_cnt != 5'd3) begin
                        r_prod <= 62'(sel_m * sel_m);
                        r_cnt  <= r_cnt + 5'd1;
                    end
                    if (r_cnt != 5'd0 && r_cnt != 5'd3) begin
                        r_sum <= r_sum + 64'(r_prod);
                    end
                    if (r_cnt == 5'd3) begin
                        r_num   <= r_sum + 64'(r_prod);
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= N_SQRT;
                    end
                end
                // integer square root, one result bit per cycle
                N_SQRT: begin
                    if (r_num >= trial) begin
                        r_num <= r_num - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_idx   <= '0;
                        r_state <= N_DVL;
                    end
                end
                // rounded dividend for one component
                N_DVL: begin
                    r_dvd   <= dvd;
                    r_rem   <= {1'b0, dvd[47:17]};
                    r_q     <= '0;
                    r_cnt   <= 5'd16;
                    r_state <= N_DVS;
                end
                // restoring divide, 17 quotient bits
                N_DVS: begin
                    r_rem <= ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
                    r_q   <= qn;
                    if (r_cnt == 5'd0) begin
                        r_out[r_idx] <= r_neg[r_idx] ? -AX_W'(qn) : AX_W'(qn);
                        if (r_idx == 2'd2) begin
                            r_state <= N_DONE;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= N_DVL;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == N_DONE);
    assign o_rsp.zero = r_zero;
    assign o_vec      = r_out;

endmodule

>>> rtl/lav_core.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: compute back end
// Sequences both normalizations, the two cross products and the three
// eye dot products over one shared multiplier, then hands off the matrix.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module lav_core import lav_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_item     i_item,
    output logic      o_pop,
    output logic      o_norm_start,
    output t_nvec     o_norm_vec [3],
    input  t_norm_rsp i_norm_rsp,
    input  t_axis     i_norm_vec [3],
    input  logic      i_emit_ready,
    output logic      o_load,
    output t_matrix   o_mat
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_NZ   = 3'd1;
    localparam logic [2:0] C_XC   = 3'd2;
    localparam logic [2:0] C_NX   = 3'd3;
    localparam logic [2:0] C_YC   = 3'd4;
    localparam logic [2:0] C_DOT  = 3'd5;
    localparam logic [2:0] C_OUT  = 3'd6;

    logic [2:0]              r_state;
    logic                    r_nstart;
    logic [2:0]              r_step;
    logic [1:0]              r_dsel;
    logic                    r_degen;
    logic signed [D_W-1:0]   r_d   [3];
    logic signed [IN_W-1:0]  r_eye [3];
    logic signed [IN_W-1:0]  r_up  [3];
    t_nvec                   r_xc  [3];
    t_axis                   r_zx  [3];
    t_axis                   r_xx  [3];
    t_axis                   r_yx  [3];
    logic signed [IN_W-1:0]  r_w   [3];
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod_full;
    logic [1:0]                ia;
    logic [1:0]                ib;
    logic [1:0]                ds;
    logic [2:0]                k;
    logic [1:0]                comp;
    logic signed [ACC_W-1:0]   diff;
    logic signed [ACC_W-1:0]   dsum;

    // multiplier operand select
    always_comb begin
        ia = xp_ia(r_step);
        ib = xp_ib(r_step);
        ds = r_step[1:0];
        case (r_state)
            C_XC: begin
                mul_a = pick3(ia, MUL_W'(r_up[0]), MUL_W'(r_up[1]), MUL_W'(r_up[2]));
                mul_b = pick3(ib, MUL_W'(r_zx[0]), MUL_W'(r_zx[1]), MUL_W'(r_zx[2]));
            end
            C_YC: begin
                mul_a = pick3(ia, MUL_W'(r_zx[0]), MUL_W'(r_zx[1]), MUL_W'(r_zx[2]));
                mul_b = pick3(ib, MUL_W'(r_xx[0]), MUL_W'(r_xx[1]), MUL_W'(r_xx[2]));
            end
            C_DOT: begin
                mul_a = pick3(r_dsel,
                    pick3(ds, MUL_W'(r_xx[0]), MUL_W'(r_xx[1]), MUL_W'(r_xx[2])),
                    pick3(ds, MUL_W'(r_yx[0]), MUL_W'(r_yx[1]), MUL_W'(r_yx[2])),
                    pick3(ds, MUL_W'(r_zx[0]), MUL_W'(r_zx[1]), MUL_W'(r_zx[2])));
                mul_b = pick3(ds, MUL_W'(r_eye[0]), MUL_W'(r_eye[1]), MUL_W'(r_eye[2]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_full = mul_a * mul_b;
        k         = r_step - 3'd1;
        comp      = k[2:1];
        diff      = r_acc - r_prod;
        dsum      = r_acc + r_prod;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_nstart <= 1'b0;
            r_step   <= '0;
            r_dsel   <= '0;
        end else begin
            r_nstart <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (!i_q_empty) begin
                        r_d[0]   <= i_item.d_x;
                        r_d[1]   <= i_item.d_y;
                        r_d[2]   <= i_item.d_z;
                        r_eye[0] <= i_item.eye_x;
                        r_eye[1] <= i_item.eye_y;
                        r_eye[2] <= i_item.eye_z;
                        r_up[0]  <= i_item.up_x;
                        r_up[1]  <= i_item.up_y;
                        r_up[2]  <= i_item.up_z;
                        r_nstart <= 1'b1;
                        r_state  <= C_NZ;
                    end
                end
                // forward axis
                C_NZ: begin
                    if (i_norm_rsp.done) begin
                        r_zx    <= i_norm_vec;
                        r_degen <= i_norm_rsp.zero;
                        r_step  <= '0;
                        r_state <= C_XC;
                    end
                end
                // up x forward, exact, then side axis normalize; forward x side, rounded, for the up axis
                C_XC, C_YC: begin
                    if (r_step != 3'd6) begin
                        r_prod <= prod_full[ACC_W-1:0];
                    end
                    if (r_step != 3'd0) begin
                        if (!k[0]) begin
                            r_acc <= r_prod;
                        end else if (r_state == C_XC) begin
                            r_xc[comp] <= diff[NV_W-1:0];
                        end else begin
                            r_yx[comp] <= AX_W'(rnd_q16(diff));
                        end
                    end
                    if (r_step == 3'd6) begin
                        r_step <= '0;
                        r_dsel <= '0;
                        if (r_state == C_XC) begin
                            r_nstart <= 1'b1;
                            r_state  <= C_NX;
                        end else begin
                            r_state <= C_DOT;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                // side axis
                C_NX: begin
                    if (i_norm_rsp.done) begin
                        r_xx    <= i_norm_vec;
                        r_degen <= r_degen | i_norm_rsp.zero;
                        r_step  <= '0;
                        r_state <= C_YC;
                    end
                end
                // negated eye dot products for the w row
                C_DOT: begin
                    if (r_step != 3'd3) begin
                        r_prod <= prod_full[ACC_W-1:0];
                        r_step <= r_step + 3'd1;
                    end
                    if (r_step == 3'd1) begin
                        r_acc <= r_prod;
                    end else if (r_step == 3'd2) begin
                        r_acc <= dsum;
                    end else if (r_step == 3'd3) begin
                        r_w[r_dsel] <= sat32(-rnd_q16(dsum));
                        r_step      <= '0;
                        if (r_dsel == 2'd2) begin
                            r_state <= C_OUT;
                        end else begin
                            r_dsel <= r_dsel + 2'd1;
                        end
                    end
                end
                C_OUT: begin
                    if (i_emit_ready) begin
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    // normalize request: forward difference first, then the side cross product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_norm_vec[i] = (r_state == C_NZ) ? NV_W'(r_d[i]) : r_xc[i];
        end
    end

    assign o_norm_start = r_nstart;
    assign o_pop        = (r_state == C_IDLE) && !i_q_empty;
    assign o_load       = (r_state == C_OUT) && i_emit_ready;

    // matrix word to the emitter
    always_comb begin
        o_mat.x0    = r_xx[0];
        o_mat.x1    = r_xx[1];
        o_mat.x2    = r_xx[2];
        o_mat.y0    = r_yx[0];
        o_mat.y1    = r_yx[1];
        o_mat.y2    = r_yx[2];
        o_mat.z0    = r_zx[0];
        o_mat.z1    = r_zx[1];
        o_mat.z2    = r_zx[2];
        o_mat.w0    = r_w[0];
        o_mat.w1    = r_w[1];
        o_mat.w2    = r_w[2];
        o_mat.degen = r_degen;
    end

    `LAV_ASSERT(a_norm_wait, i_clk, i_rst_n, i_norm_rsp.done |-> (r_state == C_NZ || r_state == C_NX), "normalize finished while core not waiting")

endmodule

>>> rtl/lav_emit.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: row emitter
// Holds one finished matrix and strobes out its four rows on consecutive cycles.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module lav_emit import lav_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_matrix                i_mat,
    output logic                   o_ready,
    output logic                   o_strobe,
    output logic [ROW_W-1:0]       o_row_index,
    output logic signed [IN_W-1:0] o_elem_0,
    output logic signed [IN_W-1:0] o_elem_1,
    output logic signed [IN_W-1:0] o_elem_2,
    output logic signed [IN_W-1:0] o_elem_3,
    output logic                   o_degenerate,
    output logic                   o_last_row
);

    logic             r_busy;
    logic [ROW_W-1:0] r_row;
    t_matrix          r_mat;

    // row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (r_busy) begin
            if (r_row == LAST_ROW) begin
                r_busy <= 1'b0;
            end
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mat <= i_mat;
        end
    end

    // row select
    always_comb begin
        case (r_row)
            2'd0: begin
                o_elem_0 = IN_W'(r_mat.x0);
                o_elem_1 = IN_W'(r_mat.y0);
                o_elem_2 = IN_W'(r_mat.z0);
                o_elem_3 = '0;
            end
            2'd1: begin
                o_elem_0 = IN_W'(r_mat.x1);
                o_elem_1 = IN_W'(r_mat.y1);
                o_elem_2 = IN_W'(r_mat.z1);
                o_elem_3 = '0;
            end
            2'd2: begin
                o_elem_0 = IN_W'(r_mat.x2);
                o_elem_1 = IN_W'(r_mat.y2);
                o_elem_2 = IN_W'(r_mat.z2);
                o_elem_3 = '0;
            end
            default: begin
                o_elem_0 = r_mat.w0;
                o_elem_1 = r_mat.w1;
                o_elem_2 = r_mat.w2;
                o_elem_3 = FIX_ONE;
            end
        endcase
    end

    assign o_ready      = !r_busy;
    assign o_strobe     = r_busy;
    assign o_row_index  = r_row;
    assign o_degenerate = r_mat.degen;
    assign o_last_row   = (r_row == LAST_ROW);

    `LAV_NEVER(a_emit_overrun, i_clk, i_rst_n, i_load && r_busy, "matrix loaded while rows still going out")
    `LAV_ASSERT(a_emit_start, i_clk, i_rst_n, i_load |=> (o_strobe && r_row == '0), "load not followed by first row")
    `LAV_ASSERT(a_emit_burst, i_clk, i_rst_n, (r_busy && r_row != LAST_ROW) |=> (r_busy && r_row == $past(r_row) + 2'd1), "row burst broken")

endmodule

>>> rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: top level
// Builds a left-handed view matrix from target, eye and up in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Command side: drive the nine Q16.16 fields and raise start; the word is
//   taken at a clock edge where start is high and busy is low. The front
//   forms target - eye and queues up to two words, so busy only rises
//   when the queue is full.
//   Result side: four rows x, y, z, w go out on consecutive cycles,
//   each marked by o_strobe for one cycle; o_last_row flags the w row.
//   The receiver cannot stall; rows are never held back.
// Timing:
//   The back end works on one word at a time and takes the next from the
//   queue once it has handed its matrix to the emitter. Its run time is set
//   by the shared normalize unit, run twice per word: range shift one bit
//   per cycle, square root, then three divides; a zero vector skips straight
//   to done. Rows of one matrix go out while the next word is worked on.
// Reset:
//   Synchronous, active low; empties the queue and drops any word in flight.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] i_target_x,
    input  logic signed [IN_W-1:0] i_target_y,
    input  logic signed [IN_W-1:0] i_target_z,
    input  logic signed [IN_W-1:0] i_eye_x,
    input  logic signed [IN_W-1:0] i_eye_y,
    input  logic signed [IN_W-1:0] i_eye_z,
    input  logic signed [IN_W-1:0] i_up_x,
    input  logic signed [IN_W-1:0] i_up_y,
    input  logic signed [IN_W-1:0] i_up_z,
    output logic                   o_strobe,
    output logic [ROW_W-1:0]       o_row_index,
    output logic signed [IN_W-1:0] o_elem_0,
    output logic signed [IN_W-1:0] o_elem_1,
    output logic signed [IN_W-1:0] o_elem_2,
    output logic signed [IN_W-1:0] o_elem_3,
    output logic                   o_degenerate,
    output logic                   o_last_row
);

    t_item     in_item;
    t_item     q_item;
    logic      push;
    logic      pop;
    logic      q_empty;
    logic      q_full;
    logic      norm_start;
    t_nvec     norm_in  [3];
    t_axis     norm_out [3];
    t_norm_rsp norm_rsp;
    logic      emit_ready;
    logic      emit_load;
    t_matrix   mat;

    // front: accept and form the forward difference exactly
    always_comb begin
        in_item.d_x   = D_W'(i_target_x) - D_W'(i_eye_x);
        in_item.d_y   = D_W'(i_target_y) - D_W'(i_eye_y);
        in_item.d_z   = D_W'(i_target_z) - D_W'(i_eye_z);
        in_item.eye_x = i_eye_x;
        in_item.eye_y = i_eye_y;
        in_item.eye_z = i_eye_z;
        in_item.up_x  = i_up_x;
        in_item.up_y  = i_up_y;
        in_item.up_z  = i_up_z;
    end

    assign push = start && !q_full;
    assign busy = q_full;

    lav_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_item),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lav_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_in),
        .o_rsp   (norm_rsp),
        .o_vec   (norm_out)
    );

    lav_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_item       (q_item),
        .o_pop        (pop),
        .o_norm_start (norm_start),
        .o_norm_vec   (norm_in),
        .i_norm_rsp   (norm_rsp),
        .i_norm_vec   (norm_out),
        .i_emit_ready (emit_ready),
        .o_load       (emit_load),
        .o_mat        (mat)
    );

    lav_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (emit_load),
        .i_mat        (mat),
        .o_ready      (emit_ready),
        .o_strobe     (o_strobe),
        .o_row_index  (o_row_index),
        .o_elem_0     (o_elem_0),
        .o_elem_1     (o_elem_1),
        .o_elem_2     (o_elem_2),
        .o_elem_3     (o_elem_3),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );

endmodule
